// ===== sv/cfr_pkg.sv =====
// Shared types and constants of the CRC frame receiver.
package cfr_pkg;

  localparam logic [31:0] FrameMagic     = 32'h3153_5052;
  localparam logic [31:0] CrcPoly        = 32'hEDB8_8320;
  localparam logic [31:0] CrcOnes        = 32'hFFFF_FFFF;
  localparam logic [31:0] MaxLengthReset = 32'h0400_0000;
  localparam logic [7:0]  EndTypeReset   = 8'h00;

  // Register index, taken from paddr[2]
  localparam logic RegMaxLength = 1'b0;
  localparam logic RegEndType   = 1'b1;

  typedef enum logic [1:0] {
    PH_CLOSED  = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_TRAILER = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_CLOSE = 2'd1,
    ACT_OPEN  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_ABORT  = 2'd2
  } kind_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  frm_type;
    logic [7:0]  data_byte;
    logic [31:0] frame_length;
  } result_t;

endpackage

// ===== sv/cfr_if.sv =====
// Stream interfaces of the CRC frame receiver: link events in, results out.
interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface cfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  frm_type;
  logic [7:0]  data_byte;
  logic [31:0] frame_length;

  modport source (output valid, output kind, output frm_type, output data_byte,
                  output frame_length, input ready);
  modport sink   (input valid, input kind, input frm_type, input data_byte,
                  input frame_length, output ready);
endinterface

// ===== sv/cfr_parser.sv =====
// Frame parser: header, payload and trailer state with the byte-wide CRC-32 update.
module cfr_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          action_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [31:0]         max_length_i,
  input  logic [7:0]          end_type_i,
  output cfr_pkg::result_t    result_o
);

  cfr_pkg::phase_e phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] rcv_q, rcv_d;

  logic [31:0] full_len;
  logic [31:0] full_rcv;
  logic [31:0] crc_next;
  logic [3:0]  len_idx;
  logic        is_open;
  cfr_pkg::result_t res;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (cfr_pkg::CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cfr_pkg::PH_CLOSED;
      pos_q   <= '0;
      type_q  <= '0;
      len_q   <= '0;
      left_q  <= '0;
      crc_q   <= cfr_pkg::CrcOnes;
      rcv_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      type_q  <= type_d;
      len_q   <= len_d;
      left_q  <= left_d;
      crc_q   <= crc_d;
      rcv_q   <= rcv_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    type_d  = type_q;
    len_d   = len_q;
    left_d  = left_q;
    crc_d   = crc_q;
    rcv_d   = rcv_q;

    res.valid        = 1'b0;
    res.kind         = cfr_pkg::KIND_DATA;
    res.frm_type     = '0;
    res.data_byte    = '0;
    res.frame_length = '0;

    // Last byte of a little-endian word lands in the top lane, still clear
    full_len = len_q | {rx_byte_i, 24'h0};
    full_rcv = rcv_q | {rx_byte_i, 24'h0};
    crc_next = crc_byte(crc_q, rx_byte_i);
    len_idx  = pos_q - 4'd5;
    is_open  = (phase_q != cfr_pkg::PH_CLOSED);

    if (accept_i) begin
      case (action_i)
        cfr_pkg::ACT_CLOSE: begin
          if (is_open) begin
            phase_d   = cfr_pkg::PH_CLOSED;
            pos_d     = '0;
            res.valid = 1'b1;
            res.kind  = cfr_pkg::KIND_ABORT;
          end
        end
        cfr_pkg::ACT_OPEN: begin
          // Abort the old connection, then start on a fresh header
          if (is_open) begin
            res.valid = 1'b1;
            res.kind  = cfr_pkg::KIND_ABORT;
          end
          phase_d = cfr_pkg::PH_HEADER;
          pos_d   = '0;
          type_d  = '0;
          len_d   = '0;
          left_d  = '0;
          crc_d   = cfr_pkg::CrcOnes;
          rcv_d   = '0;
        end
        cfr_pkg::ACT_BYTE: begin
          case (phase_q)
            cfr_pkg::PH_HEADER: begin
              case (pos_q) inside
                [4'd0:4'd3]: rcv_d[{pos_q[1:0], 3'b000} +: 8] = rx_byte_i;
                4'd4:        type_d = rx_byte_i;
                [4'd5:4'd8]: len_d[{len_idx[1:0], 3'b000} +: 8] = rx_byte_i;
                default: ;
              endcase
              if (pos_q < 4'd8) begin
                pos_d = pos_q + 4'd1;
              end else if (rcv_q != cfr_pkg::FrameMagic || full_len > max_length_i) begin
                phase_d   = cfr_pkg::PH_CLOSED;
                pos_d     = '0;
                res.valid = 1'b1;
                res.kind  = cfr_pkg::KIND_ABORT;
              end else begin
                rcv_d   = '0;
                crc_d   = cfr_pkg::CrcOnes;
                pos_d   = '0;
                left_d  = full_len;
                phase_d = (full_len == '0) ? cfr_pkg::PH_TRAILER : cfr_pkg::PH_PAYLOAD;
              end
            end
            cfr_pkg::PH_PAYLOAD: begin
              crc_d  = crc_next;
              left_d = left_q - 32'd1;
              if (left_q == 32'd1) begin
                phase_d = cfr_pkg::PH_TRAILER;
              end
              res.valid     = 1'b1;
              res.kind      = cfr_pkg::KIND_DATA;
              res.frm_type  = type_q;
              res.data_byte = rx_byte_i;
            end
            cfr_pkg::PH_TRAILER: begin
              rcv_d[{pos_q[1:0], 3'b000} +: 8] = rx_byte_i;
              if (pos_q[1:0] != 2'd3) begin
                pos_d = {2'b00, pos_q[1:0] + 2'd1};
              end else if ((crc_q ^ cfr_pkg::CrcOnes) != full_rcv) begin
                phase_d   = cfr_pkg::PH_CLOSED;
                pos_d     = '0;
                res.valid = 1'b1;
                res.kind  = cfr_pkg::KIND_ABORT;
              end else begin
                res.valid        = 1'b1;
                res.kind         = cfr_pkg::KIND_ACCEPT;
                res.frm_type     = type_q;
                res.frame_length = len_q;
                pos_d = '0;
                rcv_d = '0;
                crc_d = cfr_pkg::CrcOnes;
                if (type_q == end_type_i) begin
                  phase_d = cfr_pkg::PH_CLOSED;
                end else begin
                  phase_d = cfr_pkg::PH_HEADER;
                  len_d   = '0;
                  left_d  = '0;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign result_o = res;

  property p_close_shuts;
    @(posedge clk_i) disable iff (!rst_ni)
      accept_i && action_i == cfr_pkg::ACT_CLOSE |=> phase_q == cfr_pkg::PH_CLOSED;
  endproperty
  a_close_shuts: assert property (p_close_shuts) else $error("parser open after close");

  property p_open_fresh;
    @(posedge clk_i) disable iff (!rst_ni)
      accept_i && action_i == cfr_pkg::ACT_OPEN |=>
        phase_q == cfr_pkg::PH_HEADER && pos_q == 4'd0 && crc_q == cfr_pkg::CrcOnes;
  endproperty
  a_open_fresh: assert property (p_open_fresh) else $error("open did not restart header");

  property p_data_in_payload;
    @(posedge clk_i) disable iff (!rst_ni)
      res.valid && res.kind == cfr_pkg::KIND_DATA |-> phase_q == cfr_pkg::PH_PAYLOAD;
  endproperty
  a_data_in_payload: assert property (p_data_in_payload) else $error("data outside payload");

  property p_closed_no_result;
    @(posedge clk_i) disable iff (!rst_ni)
      phase_q == cfr_pkg::PH_CLOSED && action_i != cfr_pkg::ACT_OPEN |-> !res.valid;
  endproperty
  a_closed_no_result: assert property (p_closed_no_result) else $error("result while closed");

endmodule

// ===== sv/crc_frame_receiver.sv =====
// Top level of the CRC frame receiver: APB registers, parser and result register.
// One link event (byte, close or open) is taken per cycle; its result, if any, is in the
// result register on the next cycle. Parsing state and the byte-wide CRC-32 update sit
// between the parser's state registers and that result register, so the input is stalled
// only while the result register holds a transfer the sink has not yet taken. Payload
// bytes are passed on as they arrive; discard a frame's payload on abort. No clearing pass.
module crc_frame_receiver (
  input  logic              clk_i,
  input  logic              rst_ni,
  cfr_in_if.sink            in_if,
  cfr_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0] max_length_q;
  logic [7:0]  end_type_q;
  logic        cfg_we;
  logic        in_accept;
  logic        out_valid_q, out_valid_d;
  cfr_pkg::result_t out_q;
  cfr_pkg::result_t res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == cfr_pkg::RegEndType) ? {24'h0, end_type_q} : max_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= cfr_pkg::MaxLengthReset;
      end_type_q   <= cfr_pkg::EndTypeReset;
    end else if (cfg_we) begin
      if (paddr[2] == cfr_pkg::RegMaxLength) begin
        max_length_q <= pwdata;
      end else begin
        end_type_q <= pwdata[7:0];
      end
    end
  end

  // Accept whenever the result register is empty or being drained
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_accept   = in_if.valid && in_if.ready;

  cfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .action_i     (in_if.action),
    .rx_byte_i    (in_if.rx_byte),
    .max_length_i (max_length_q),
    .end_type_i   (end_type_q),
    .result_o     (res)
  );

  always_comb begin
    if (in_accept) begin
      out_valid_d = res.valid;
    end else begin
      out_valid_d = out_valid_q && !out_if.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && res.valid) begin
      out_q <= res;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.kind         = out_q.kind;
  assign out_if.frm_type     = out_q.frm_type;
  assign out_if.data_byte    = out_q.data_byte;
  assign out_if.frame_length = out_q.frame_length;

  property p_result_lands;
    @(posedge clk_i) disable iff (!rst_ni)
      in_accept && res.valid |=> out_valid_q;
  endproperty
  a_result_lands: assert property (p_result_lands) else $error("result lost");

  property p_no_overrun;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && !out_if.ready |-> !in_accept;
  endproperty
  a_no_overrun: assert property (p_no_overrun) else $error("result register overrun");

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && !out_if.ready |=> out_valid_q && $stable(out_q);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("waiting result changed");

endmodule
